// ===== rtl/dci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dci_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int CFG_W             = 13;
    localparam logic [CFG_W-1:0] RESET_MAX_ENTRIES = 13'd4096;

    // register index (byte address / 4)
    localparam logic REG_MAX_ENTRIES = 1'b0;

    // request kinds
    localparam logic [1:0] REQ_LOOKUP    = 2'd0;
    localparam logic [1:0] REQ_INS_BLOCK = 2'd1;
    localparam logic [1:0] REQ_INS_DEFER = 2'd2;
    localparam logic [1:0] REQ_IGNORE    = 2'd3;

    // result status
    localparam logic [2:0] STAT_ADDED   = 3'd0;
    localparam logic [2:0] STAT_DUP     = 3'd1;
    localparam logic [2:0] STAT_CAP     = 3'd2;
    localparam logic [2:0] STAT_IGNORED = 3'd3;
    localparam logic [2:0] STAT_LOOKUP  = 3'd4;

    typedef struct packed {
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
        logic [7:0]  calg;
        logic [7:0]  zalg;
        logic [24:0] lsize;
        logic [24:0] psize;
    } key_t;

    typedef struct packed {
        logic        valid;
        key_t        key;
        logic        deferred;
        logic [63:0] ref_val;
        logic [63:0] obj;
        logic [63:0] off;
    } entry_t;

    localparam int KEY_W   = $bits(key_t);
    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/dci_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dci_hash #(
    parameter int AW = 12
) (
    input  wire dci_pkg::key_t key,
    output logic [AW-1:0]      slot
);

    logic [dci_pkg::KEY_W-1:0] kbits;

    assign kbits = key;

    // fold every key bit onto the index with XOR
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < dci_pkg::KEY_W; i++)
        begin
            slot[i % AW] = slot[i % AW] ^ kbits[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dci_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dci_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire                  clk,
    input  wire                  wr_en,
    input  wire [AW-1:0]         wr_addr,
    input  wire dci_pkg::entry_t wr_data,
    input  wire [AW-1:0]         rd_addr,
    output dci_pkg::entry_t      rd_data
);

    dci_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/dedup_checksum_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Exact-match dedup index built as an open-addressed hash table in one
// synchronous RAM of TABLE_ENTRIES rows. A key hashes to a home slot and the
// engine probes forward one slot per cycle (the RAM read is registered) until
// it finds the key or an empty slot, or has probed every slot. A request is
// accepted in S_IDLE, probed slot by slot in S_PROBE and posts its result from
// S_DONE once the output is free; probe chains grow as the table fills. Ignored
// requests and inserts refused at the cap go from S_IDLE straight to S_DONE.
// One request is in work at a time; the next is taken while the previous
// result waits on the output. After reset a clearing pass writes every row to
// empty the RAM; no request is accepted during it, register writes are.
module dedup_checksum_index #(
    parameter int TABLE_ENTRIES = dci_pkg::DEF_TABLE_ENTRIES
) (
    input  wire          clk,
    input  wire          rst_n,
    // cksum_word0..3, checksum_alg, compress_alg, logical_size,
    // physical_size, block_ref, object_id, block_offset (bit 0 up)
    input  wire [519:0]  s_tdata,
    input  wire [1:0]    s_tuser,   // req_type
    input  wire          s_tvalid,
    output logic         s_tready,
    // hit, is_deferred, found_ref, found_object, found_offset, entries_now
    output logic [207:0] m_tdata,
    output logic [2:0]   m_tuser,   // insert_status
    output logic         m_tvalid,
    input  wire          m_tready,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (CW > dci_pkg::CFG_W) ? CW : dci_pkg::CFG_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [AW-1:0]             addr_reg;
    logic [AW-1:0]             probe_reg;
    logic [CW-1:0]             count_reg;
    logic [dci_pkg::CFG_W-1:0] max_reg;
    logic [1:0]                req_reg;
    dci_pkg::key_t             key_reg;
    logic [63:0]               ref_reg;
    logic [63:0]               obj_reg;
    logic [63:0]               off_reg;
    logic                      res_hit_reg;
    logic                      res_dfr_reg;
    logic [63:0]               res_ref_reg;
    logic [63:0]               res_obj_reg;
    logic [63:0]               res_off_reg;
    logic [2:0]                res_stat_reg;
    logic                      out_valid_reg;
    logic                      out_hit_reg;
    logic                      out_dfr_reg;
    logic [63:0]               out_ref_reg;
    logic [63:0]               out_obj_reg;
    logic [63:0]               out_off_reg;
    logic [2:0]                out_stat_reg;
    logic [12:0]               out_cnt_reg;

    dci_pkg::key_t   in_key;
    logic [AW-1:0]   in_hash;
    logic [AW-1:0]   rd_addr;
    dci_pkg::entry_t rd_entry;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    dci_pkg::entry_t wr_data;
    dci_pkg::entry_t new_entry;
    logic [CMPW-1:0] max_ext;
    logic [CMPW-1:0] cap_eff;
    logic            at_cap;
    logic            is_match;
    logic            is_empty;
    logic            last_probe;
    logic            is_insert;
    logic            out_free;
    logic            cfg_wr;

    assign in_key.w0    = s_tdata[63:0];
    assign in_key.w1    = s_tdata[127:64];
    assign in_key.w2    = s_tdata[191:128];
    assign in_key.w3    = s_tdata[255:192];
    assign in_key.calg  = s_tdata[263:256];
    assign in_key.zalg  = s_tdata[271:264];
    assign in_key.lsize = s_tdata[296:272];
    assign in_key.psize = s_tdata[321:297];

    dci_hash #(
        .AW (AW)
    ) u_hash (
        .key  (in_key),
        .slot (in_hash)
    );

    dci_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign max_ext    = CMPW'(max_reg);
    assign cap_eff    = (max_ext > CMPW'(TABLE_ENTRIES)) ? CMPW'(TABLE_ENTRIES) : max_ext;
    assign at_cap     = CMPW'(count_reg) >= cap_eff;
    assign is_insert  = (req_reg == dci_pkg::REQ_INS_BLOCK)
                     || (req_reg == dci_pkg::REQ_INS_DEFER);
    assign is_match   = rd_entry.valid && (rd_entry.key == key_reg);
    assign is_empty   = !rd_entry.valid;
    assign last_probe = probe_reg == AW'(TABLE_ENTRIES - 1);
    assign out_free   = !out_valid_reg || m_tready;
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign rd_addr = (state_reg == S_PROBE) ? addr_reg + 1'b1 : in_hash;

    always_comb
    begin
        new_entry.valid    = 1'b1;
        new_entry.key      = key_reg;
        new_entry.deferred = (req_reg == dci_pkg::REQ_INS_DEFER);
        new_entry.ref_val  = new_entry.deferred ? 64'd0 : ref_reg;
        new_entry.obj      = new_entry.deferred ? obj_reg : 64'd0;
        new_entry.off      = new_entry.deferred ? off_reg : 64'd0;

        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = new_entry;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_PROBE && is_insert && is_empty)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            max_reg       <= dci_pkg::RESET_MAX_ENTRIES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == dci_pkg::REG_MAX_ENTRIES)
            begin
                max_reg <= pwdata[dci_pkg::CFG_W-1:0];
            end
            // load a finished result, else drop the word once taken
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_reg      <= s_tuser;
                        key_reg      <= in_key;
                        ref_reg      <= s_tdata[385:322];
                        obj_reg      <= s_tdata[449:386];
                        off_reg      <= s_tdata[513:450];
                        res_hit_reg  <= 1'b0;
                        res_dfr_reg  <= 1'b0;
                        res_ref_reg  <= '0;
                        res_obj_reg  <= '0;
                        res_off_reg  <= '0;
                        addr_reg     <= in_hash;
                        probe_reg    <= '0;
                        if (s_tuser == dci_pkg::REQ_IGNORE)
                        begin
                            res_stat_reg <= dci_pkg::STAT_IGNORED;
                            state_reg    <= S_DONE;
                        end
                        else if (s_tuser != dci_pkg::REQ_LOOKUP && at_cap)
                        begin
                            res_stat_reg <= dci_pkg::STAT_CAP;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_PROBE;
                        end
                    end
                end
                S_PROBE:
                begin
                    if (is_match)
                    begin
                        if (is_insert)
                        begin
                            res_stat_reg <= dci_pkg::STAT_DUP;
                        end
                        else
                        begin
                            res_stat_reg <= dci_pkg::STAT_LOOKUP;
                            res_hit_reg  <= 1'b1;
                            res_dfr_reg  <= rd_entry.deferred;
                            res_ref_reg  <= rd_entry.ref_val;
                            res_obj_reg  <= rd_entry.obj;
                            res_off_reg  <= rd_entry.off;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (is_empty || last_probe)
                    begin
                        if (!is_insert)
                        begin
                            res_stat_reg <= dci_pkg::STAT_LOOKUP;
                        end
                        else if (is_empty)
                        begin
                            res_stat_reg <= dci_pkg::STAT_ADDED;
                            count_reg    <= count_reg + 1'b1;
                        end
                        else
                        begin
                            res_stat_reg <= dci_pkg::STAT_CAP;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // advance to the next slot of the chain
                        addr_reg  <= addr_reg + 1'b1;
                        probe_reg <= probe_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_hit_reg   <= res_hit_reg;
                        out_dfr_reg   <= res_dfr_reg;
                        out_ref_reg   <= res_ref_reg;
                        out_obj_reg   <= res_obj_reg;
                        out_off_reg   <= res_off_reg;
                        out_stat_reg  <= res_stat_reg;
                        out_cnt_reg   <= 13'(count_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_off_reg, out_obj_reg, out_ref_reg,
                       out_dfr_reg, out_hit_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == dci_pkg::REG_MAX_ENTRIES) ? 32'(max_reg) : 32'd0;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count jumped");

    a_count_add: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_PROBE && $past(wr_en)))
        else $error("entry count moved without a table write");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("table written outside clear or probe");

endmodule

`default_nettype wire
